>>> rtl/core/ifrc_pkg.sv
// ----------------------------------------------------------------------------
// ifrc_pkg: shared types and constants for the flip/rotate/crop frame store
// Item formats, register indexes, transform codes and frame dimensions.
// ----------------------------------------------------------------------------
package ifrc_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  // Wide enough for a 9-bit register value and for the largest frame size.
  localparam int DIM_W    = 13;

  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_ROT_CCW = 3'd1;
  localparam logic [2:0] MODE_ROT_180 = 3'd2;
  localparam logic [2:0] MODE_ROT_CW  = 3'd3;
  localparam logic [2:0] MODE_FLIP_V  = 3'd4;
  localparam logic [2:0] MODE_FLIP_H  = 3'd5;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_FRAME_ROWS = 3'd1;
  localparam logic [2:0] REG_FRAME_COLS = 3'd2;
  localparam logic [2:0] REG_CROP_ROW_A = 3'd3;
  localparam logic [2:0] REG_CROP_COL_A = 3'd4;
  localparam logic [2:0] REG_CROP_ROW_B = 3'd5;
  localparam logic [2:0] REG_CROP_COL_B = 3'd6;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [2:0] transform_mode;
    logic [8:0] frame_rows;
    logic [8:0] frame_cols;
    logic [7:0] crop_row_a;
    logic [7:0] crop_col_a;
    logic [7:0] crop_row_b;
    logic [7:0] crop_col_b;
  } cfg_t;

  // Access handed from the address mapper to the frame store.
  typedef struct packed {
    logic              valid;
    logic              rd;
    logic              wr;
    logic              err;
    logic [ROW_AW-1:0] row;
    logic [COL_AW-1:0] col;
    logic [7:0]        pixel;
  } mem_req_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [8:0] v, input int lim);
    logic [DIM_W-1:0] ve;
    logic [DIM_W-1:0] le;
    ve = DIM_W'(v);
    le = DIM_W'(lim);
    return (ve > le) ? le : ve;
  endfunction

endpackage

>>> rtl/core/ifrc_cfg.sv
// ----------------------------------------------------------------------------
// ifrc_cfg: configuration registers
// Holds transform mode, frame size and crop corners, written by index.
// ----------------------------------------------------------------------------
module ifrc_cfg import ifrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE:       cfg_nxt.transform_mode = cfg_wdata[2:0];
        REG_FRAME_ROWS: cfg_nxt.frame_rows     = cfg_wdata;
        REG_FRAME_COLS: cfg_nxt.frame_cols     = cfg_wdata;
        REG_CROP_ROW_A: cfg_nxt.crop_row_a     = cfg_wdata[7:0];
        REG_CROP_COL_A: cfg_nxt.crop_col_a     = cfg_wdata[7:0];
        REG_CROP_ROW_B: cfg_nxt.crop_row_b     = cfg_wdata[7:0];
        REG_CROP_COL_B: cfg_nxt.crop_col_b     = cfg_wdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transform_mode <= MODE_NONE;
      cfg_r.frame_rows     <= 9'd256;
      cfg_r.frame_cols     <= 9'd256;
      cfg_r.crop_row_a     <= 8'd0;
      cfg_r.crop_col_a     <= 8'd0;
      cfg_r.crop_row_b     <= 8'd255;
      cfg_r.crop_col_b     <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/ifrc_map.sv
// ----------------------------------------------------------------------------
// ifrc_map: three-stage coordinate mapper
// Crop bounds, transformed-frame check and source offset, then final address.
// ----------------------------------------------------------------------------
module ifrc_map import ifrc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output mem_req_t req
);

  // Stage 1: crop rectangle and frame checks.
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_row_r, s1_col_r, s1_pix_r;
  logic [7:0] s1_r0_r, s1_c0_r, s1_hm1_r, s1_wm1_r;
  logic       s1_bad_r, s1_wr_ok_r;
  logic [2:0] s1_mode_r;

  logic [DIM_W-1:0] rows, cols;
  logic [7:0]       r0, r1, c0, c1;
  logic             bad_nxt, wr_ok_nxt;

  always_comb begin
    rows = clamp_dim(cfg.frame_rows, MAX_ROWS);
    cols = clamp_dim(cfg.frame_cols, MAX_COLS);
    r0 = (cfg.crop_row_a < cfg.crop_row_b) ? cfg.crop_row_a : cfg.crop_row_b;
    r1 = (cfg.crop_row_a < cfg.crop_row_b) ? cfg.crop_row_b : cfg.crop_row_a;
    c0 = (cfg.crop_col_a < cfg.crop_col_b) ? cfg.crop_col_a : cfg.crop_col_b;
    c1 = (cfg.crop_col_a < cfg.crop_col_b) ? cfg.crop_col_b : cfg.crop_col_a;
    bad_nxt = (DIM_W'(r1) >= rows) || (DIM_W'(c1) >= cols) || (cfg.transform_mode > MODE_FLIP_H);
    wr_ok_nxt = (DIM_W'(in_data.row) < rows) && (DIM_W'(in_data.col) < cols);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r   <= in_data.command;
      s1_row_r   <= in_data.row;
      s1_col_r   <= in_data.col;
      s1_pix_r   <= in_data.pixel_in;
      s1_r0_r    <= r0;
      s1_c0_r    <= c0;
      s1_hm1_r   <= r1 - r0;
      s1_wm1_r   <= c1 - c0;
      s1_bad_r   <= bad_nxt;
      s1_wr_ok_r <= wr_ok_nxt;
      s1_mode_r  <= cfg.transform_mode;
    end
  end

  // Stage 2: output bounds and offset inside the crop.
  logic       s2_valid_r;
  logic       s2_rd_r, s2_wr_r, s2_err_r;
  logic [7:0] s2_base_r_r, s2_base_c_r, s2_sr_r, s2_sc_r, s2_pix_r;

  logic       swap;
  logic [7:0] orm1, ocm1;
  logic [7:0] sr, sc;
  logic       err_nxt;

  always_comb begin
    swap = (s1_mode_r == MODE_ROT_CCW) || (s1_mode_r == MODE_ROT_CW);
    orm1 = swap ? s1_wm1_r : s1_hm1_r;
    ocm1 = swap ? s1_hm1_r : s1_wm1_r;
    err_nxt = s1_bad_r || (s1_row_r > orm1) || (s1_col_r > ocm1);
    case (s1_mode_r)
      MODE_ROT_CCW: begin sr = s1_col_r;            sc = s1_wm1_r - s1_row_r; end
      MODE_ROT_180: begin sr = s1_hm1_r - s1_row_r; sc = s1_wm1_r - s1_col_r; end
      MODE_ROT_CW:  begin sr = s1_hm1_r - s1_col_r; sc = s1_row_r;            end
      MODE_FLIP_V:  begin sr = s1_hm1_r - s1_row_r; sc = s1_col_r;            end
      MODE_FLIP_H:  begin sr = s1_row_r;            sc = s1_wm1_r - s1_col_r; end
      default:      begin sr = s1_row_r;            sc = s1_col_r;            end
    endcase
    // A store goes to its own coordinate with no crop offset.
    if (s1_cmd_r == CMD_STORE) begin
      sr = s1_row_r;
      sc = s1_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rd_r     <= s1_cmd_r == CMD_READ;
      s2_wr_r     <= (s1_cmd_r == CMD_STORE) && s1_wr_ok_r;
      s2_err_r    <= err_nxt;
      s2_base_r_r <= (s1_cmd_r == CMD_STORE) ? 8'd0 : s1_r0_r;
      s2_base_c_r <= (s1_cmd_r == CMD_STORE) ? 8'd0 : s1_c0_r;
      s2_sr_r     <= sr;
      s2_sc_r     <= sc;
      s2_pix_r    <= s1_pix_r;
    end
  end

  // Stage 3: final store address. For an in-range read the sum never passes the larger corner.
  mem_req_t s3_r;
  logic [7:0] arow, acol;

  assign arow = s2_base_r_r + s2_sr_r;
  assign acol = s2_base_c_r + s2_sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s3_r.valid <= s2_valid_r;
      s3_r.rd    <= s2_rd_r;
      s3_r.wr    <= s2_wr_r;
      s3_r.err   <= s2_err_r;
      s3_r.row   <= ROW_AW'(arow);
      s3_r.col   <= COL_AW'(acol);
      s3_r.pixel <= s2_pix_r;
    end
  end

  assign req = s3_r;

endmodule

>>> rtl/core/ifrc_store.sv
// ----------------------------------------------------------------------------
// ifrc_store: frame memory and result register
// One-port pixel memory; a read's data lands in the result register.
// ----------------------------------------------------------------------------
module ifrc_store import ifrc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  mem_req_t  req,
  output logic      out_valid,
  output out_item_t out_data
);

  logic [7:0] mem [MAX_ROWS][MAX_COLS];
  logic [7:0] rd_data_r;
  logic       out_valid_r;
  logic       err_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (req.valid && req.wr) begin
        mem[req.row][req.col] <= req.pixel;
      end
      rd_data_r <= mem[req.row][req.col];
      err_r     <= req.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= req.valid && req.rd;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.pixel_out    = err_r ? 8'd0 : rd_data_r;
  assign out_data.out_of_range = err_r;

endmodule

>>> rtl/core/image_flip_rotate_crop.sv
// ----------------------------------------------------------------------------
// image_flip_rotate_crop: frame store with cropped, rotated or flipped read-out
// Top level joining configuration, address mapping and frame memory.
// ----------------------------------------------------------------------------
// Usage: an item on the in_ channel (valid/ready) either stores pixel_in at
// row and col of the frame, or reads the pixel at output coordinate row/col
// of the cropped and transformed image. Stores give no result; each read
// gives one item on the out_ channel with the pixel, or out_of_range set
// and a zero pixel when the coordinate, the crop or the mode is invalid.
// Configuration goes through cfg_we, cfg_index and cfg_wdata while no
// item is in flight.
// From acceptance to out_valid an item passes the crop checks loaded by the
// accepting edge, then offset mapping, address add and the registered memory
// read. While out_ready does not hold the pipeline, one item is taken every
// cycle; the single port of the frame memory serves one store or one read per
// cycle, so stores and reads keep their order.
// When the receiver holds out_ready low with a result pending, the whole
// pipeline holds and in_ready falls; nothing is lost or repeated.
// Reset clears all valid bits and restores the register defaults; the frame
// memory is not cleared and a pixel must be stored before it is read.
// ----------------------------------------------------------------------------
module image_flip_rotate_crop import ifrc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_wdata
);

  cfg_t     cfg;
  mem_req_t req;
  logic     en;

  // The pipeline moves whenever the result register is free or being taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ifrc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ifrc_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg),
    .req      (req)
  );

  ifrc_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .req       (req),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
